/* design/rfpm_pkg.sv */
// ---------------------------------------------------------------------------
// rfpm_pkg
// Shared types and constants for the reciprocal frequency ppm meter.
// ---------------------------------------------------------------------------
package rfpm_pkg;

  // Input operation codes
  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Reciprocal divide: 32768 Hz times 1e6 reference ticks per second
  localparam int              NUM_W          = 35;
  localparam logic [NUM_W-1:0] FREQ_NUMERATOR = 35'd32768000000;
  localparam int              CNT_W          = 6;

  // Error scaling: (freq - nominal) * 1000 / 32
  localparam logic [31:0]        NOMINAL_HZ = 32'd32768;
  localparam int                 PROD_W     = 45;
  localparam logic signed [10:0] PPM_SCALE  = 11'sd1000;
  localparam int                 PPM_SHIFT  = 5;
  localparam logic signed [PROD_W-1:0] PPM_BIAS = 45'sd31;

  // Job queue between front and back
  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = 1;

  // One pending measurement
  typedef struct packed {
    logic [31:0] tick_diff;
    logic [15:0] meas_count;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic emit;
  } back_ctl_t;

endpackage

/* design/rfpm_front.sv */
// ---------------------------------------------------------------------------
// rfpm_front
// Accepts input words, keeps the overflow count and last timestamp, and
// queues a job for every tick that completes a measurement.
// ---------------------------------------------------------------------------
module rfpm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  logic [15:0]      in_timer_count,
  input  rfpm_pkg::q_stat_t q_stat,
  output logic             push,
  output rfpm_pkg::job_t   job
);
  import rfpm_pkg::*;

  logic [15:0] ovf_r, ovf_nxt;
  logic [31:0] last_r, last_nxt;
  logic        first_r, first_nxt;
  logic [15:0] done_r, done_nxt;

  logic        accept;
  logic        is_tick;
  logic [31:0] stamp;

  // Handshake: only back-pressure from a full queue
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (in_operation == OP_TICK);

  // Timestamp and measurement decision
  assign stamp = {ovf_r, in_timer_count};
  assign push  = accept && is_tick && !first_r && (stamp != last_r);

  assign job.tick_diff  = stamp - last_r;
  assign job.meas_count = done_r + 16'd1;

  // State update
  always_comb begin
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    if (accept) begin
      if (is_tick) begin
        last_nxt  = stamp;
        first_nxt = 1'b0;
        if (push) begin
          done_nxt = done_r + 16'd1;
        end
      end else begin
        ovf_nxt = ovf_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r   <= '0;
      last_r  <= '0;
      first_r <= 1'b1;
      done_r  <= '0;
    end else begin
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
      first_r <= first_nxt;
      done_r  <= done_nxt;
    end
  end

  // A measurement always carries a non-zero interval
  a_diff_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (job.tick_diff != 32'd0))
    else $error("front: zero interval queued");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (done_r == $past(done_r) + 16'd1))
    else $error("front: measurement count did not advance");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_tick) |=> !first_r)
    else $error("front: first-tick flag still set after a tick");

endmodule

/* design/rfpm_queue.sv */
// ---------------------------------------------------------------------------
// rfpm_queue
// Short job queue decoupling the front end from the serial back end.
// ---------------------------------------------------------------------------
module rfpm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfpm_pkg::job_t    push_job,
  input  logic              pop,
  output rfpm_pkg::job_t    pop_job,
  output rfpm_pkg::q_stat_t q_stat
);
  import rfpm_pkg::*;

  job_t             entry_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JQ_AW:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (JQ_AW+1)'(JQ_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = entry_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue: push while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue: pop while empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (JQ_AW+1)'(JQ_DEPTH))
    else $error("queue: fill count out of range");

endmodule

/* design/rfpm_back.sv */
// ---------------------------------------------------------------------------
// rfpm_back
// Serial reciprocal divide, ppm scaling and the output word register.
// ---------------------------------------------------------------------------
module rfpm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rfpm_pkg::q_stat_t q_stat,
  input  rfpm_pkg::job_t    job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_tick_diff,
  output logic [31:0]       out_frequency_hz,
  output logic signed [31:0] out_error_ppm,
  output logic [15:0]       out_measurement_count
);
  import rfpm_pkg::*;

  back_state_t state_r, state_nxt;
  back_ctl_t   ctl;

  logic [31:0]             div_r;
  logic [15:0]             mcnt_r;
  logic [NUM_W-1:0]        num_r;
  logic [31:0]             rem_r;
  logic [31:0]             quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [PROD_W-1:0] prod_r;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_diff_r;
  logic [31:0] out_freq_r;
  logic [31:0] out_ppm_r;
  logic [15:0] out_mcnt_r;

  logic                     out_free;
  logic [32:0]              rem_sh;
  logic                     ge;
  logic [32:0]              rem_sub;
  logic signed [33:0]       err_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] biased_c;
  logic signed [PROD_W-1:0] scaled_c;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_stat.empty) state_nxt = B_DIV;
      B_DIV:  if (cnt_r == '0) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_EMIT;
      B_EMIT: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      B_IDLE: ctl.load = !q_stat.empty;
      B_DIV:  ctl.step = 1'b1;
      B_MUL:  ctl.mul  = 1'b1;
      B_EMIT: ctl.emit = out_free;
      default: ctl = '0;
    endcase
  end

  assign pop = ctl.load;

  // One restoring divide step: one quotient bit per cycle
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};

  // Error scaling, truncated toward zero
  assign err_c    = $signed({2'b00, quo_r}) - $signed({2'b00, NOMINAL_HZ});
  assign prod_c   = PROD_W'(err_c) * PROD_W'(PPM_SCALE);
  assign biased_c = prod_r + (prod_r[PROD_W-1] ? PPM_BIAS : '0);
  assign scaled_c = biased_c >>> PPM_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      div_r  <= job.tick_diff;
      mcnt_r <= job.meas_count;
      num_r  <= FREQ_NUMERATOR;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= CNT_W'(NUM_W - 1);
    end else if (ctl.step) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_r <= {quo_r[30:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (ctl.mul) begin
      prod_r <= prod_c;
    end
  end

  // Output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_diff_r <= div_r;
      out_freq_r <= quo_r;
      out_ppm_r  <= scaled_c[31:0];
      out_mcnt_r <= mcnt_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_tick_diff         = out_diff_r;
  assign out_frequency_hz      = out_freq_r;
  assign out_error_ppm         = $signed(out_ppm_r);
  assign out_measurement_count = out_mcnt_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (div_r != 32'd0))
    else $error("back: divide by zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < div_r))
    else $error("back: partial remainder not below divisor");

  a_load_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !q_stat.empty)
    else $error("back: job taken from empty queue");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r)
    else $error("back: emitted word not presented");

endmodule

/* design/reciprocal_frequency_ppm_meter.sv */
// ---------------------------------------------------------------------------
// reciprocal_frequency_ppm_meter
// Measures a 32768 Hz crystal against a 1 MHz reference timer.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per event. in_operation low
// is a reference timer overflow, high is a one-second tick carrying the
// captured in_timer_count. A word is taken when in_valid is high and
// in_stall low; in_stall rises only while the two-entry job queue is full.
// Output channel (out_valid / out_stall): one word per completed
// measurement with tick interval, frequency, ppm error and count.
// A measuring tick goes into the queue, is loaded by the back end, runs 35
// divide steps (one quotient bit per cycle in the restoring divider), then
// the ppm multiply, and its word is registered for out_valid. The back end
// works on one measurement at a time while the queue takes further jobs;
// overflow words and ticks that yield no result are accepted while the
// queue has room.
// Reset (rst_n low, synchronous) clears the counters, arms the first-tick
// flag, empties the queue and drops out_valid. A stalled output word holds;
// the divider then waits and the queue absorbs up to two further jobs.
// ---------------------------------------------------------------------------
module reciprocal_frequency_ppm_meter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [15:0]        in_timer_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_tick_diff,
  output logic [31:0]        out_frequency_hz,
  output logic signed [31:0] out_error_ppm,
  output logic [15:0]        out_measurement_count
);
  import rfpm_pkg::*;

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    pop_job;
  q_stat_t q_stat;

  // Front end: event handling and timestamping
  rfpm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_timer_count (in_timer_count),
    .q_stat         (q_stat),
    .push           (push),
    .job            (push_job)
  );

  // Job queue
  rfpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // Back end: divide, scale, output register
  rfpm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .job                   (pop_job),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tick_diff         (out_tick_diff),
    .out_frequency_hz      (out_frequency_hz),
    .out_error_ppm         (out_error_ppm),
    .out_measurement_count (out_measurement_count)
  );

endmodule
